// ===== rtl/tpq_pkg.sv =====
// Shared widths, status codes and action codes of the threshold priority queue.
package tpq_pkg;

    localparam int AGE_W        = 7;
    localparam int PLATE_PORT_W = 56;
    localparam int STATUS_W     = 2;

    localparam logic [AGE_W-1:0] PRIO_AGE_RESET = AGE_W'(60);

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_action;

endpackage

// ===== rtl/threshold_priority_queue_core.sv =====
// Threshold priority queue: bounded circular-buffer queue with sorted priority insert.
// An item is taken when start is high and busy is low; its single result shows on
// o_valid for one cycle and cannot be stalled. A full enqueue or an empty dequeue
// answers from idle without touching the RAM; a dequeue reads the head entry, then
// returns it; a plain tail enqueue writes at the tail. A priority enqueue scans from the
// head, one RAM read and one compare per examined entry, then moves every entry behind
// the insert point one slot toward the tail (one RAM read, one RAM write each), working
// back from the tail, and then writes the new entry. The single-port entry RAM is why
// each read and each write takes its own state.
module threshold_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PLATE_CHARS = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic [tpq_pkg::PLATE_PORT_W-1:0]   i_plate,
    input  logic [tpq_pkg::AGE_W-1:0]          i_driver_age,
    output logic                               o_valid,
    output logic [tpq_pkg::PLATE_PORT_W-1:0]   o_out_plate,
    output logic [tpq_pkg::STATUS_W-1:0]       o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tpq_pkg::AGE_W-1:0]          i_cfg_data
);

    localparam int AGE_W   = tpq_pkg::AGE_W;
    localparam int PORT_W  = tpq_pkg::PLATE_PORT_W;
    localparam int PLATE_W = (PLATE_CHARS * 8 > PORT_W) ? PORT_W : PLATE_CHARS * 8;
    localparam int ENTRY_W = PLATE_W + AGE_W;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_DQ_RD,
        S_DQ_OUT
    } t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_head, n_head;
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic [OCC_W-1:0]       r_idx, n_idx;
    logic [OCC_W-1:0]       r_pos, n_pos;
    logic [PLATE_W-1:0]     r_plate, n_plate;
    logic [AGE_W-1:0]       r_age, n_age;
    logic [AGE_W-1:0]       r_prio;
    logic                   r_valid, n_valid;
    logic [PORT_W-1:0]      r_out_plate, n_out_plate;
    tpq_pkg::t_status       r_status, n_status;

    logic [OCC_W-1:0]       lidx;
    logic [OCC_W:0]         addr_sum;
    logic [OCC_W:0]         addr_wrap;
    logic [IDX_W-1:0]       ram_addr;
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [AGE_W-1:0]       rd_age;
    logic [PLATE_W-1:0]     rd_plate;
    logic                   accept;
    logic                   full;

    // shared address unit: logical index -> physical slot (head relative, wraps once)
    assign lidx      = (r_state == S_SHIFT_RD) ? (r_idx - OCC_W'(1)) : r_idx;
    assign addr_sum  = {1'b0, OCC_W'(r_head)} + {1'b0, lidx};
    assign addr_wrap = (addr_sum >= (OCC_W+1)'(QUEUE_DEPTH))
                     ? (addr_sum - (OCC_W+1)'(QUEUE_DEPTH)) : addr_sum;
    assign ram_addr  = addr_wrap[IDX_W-1:0];

    assign ram_we    = (r_state == S_SHIFT_WR) || (r_state == S_WRITE);
    assign ram_wdata = (r_state == S_WRITE) ? {r_plate, r_age} : ram_rdata;
    assign rd_age    = ram_rdata[AGE_W-1:0];
    assign rd_plate  = ram_rdata[ENTRY_W-1:AGE_W];

    tpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign accept = start && (r_state == S_IDLE);
    assign full   = (r_occ == OCC_W'(QUEUE_DEPTH));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_plate     = r_plate;
        n_age       = r_age;
        n_valid     = 1'b0;
        n_out_plate = '0;
        n_status    = tpq_pkg::ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == tpq_pkg::ACT_DEQ) begin
                        if (r_occ == '0) begin
                            n_valid  = 1'b1;
                            n_status = tpq_pkg::ST_EMPTY;
                        end else begin
                            n_idx   = '0;
                            n_state = S_DQ_RD;
                        end
                    end else if (full) begin
                        n_valid  = 1'b1;
                        n_status = tpq_pkg::ST_FULL;
                    end else begin
                        n_plate = i_plate[PLATE_W-1:0];
                        n_age   = i_driver_age;
                        if (i_driver_age >= r_prio) begin
                            n_idx   = '0;
                            n_state = S_SCAN_RD;
                        end else begin
                            n_idx   = r_occ;
                            n_pos   = r_occ;
                            n_state = S_SHIFT_RD;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_occ) begin
                    // no lower age stored: tail insert
                    n_pos   = r_occ;
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (rd_age < r_age) begin
                    n_pos   = r_idx;
                    n_idx   = r_occ;
                    n_state = S_SHIFT_RD;
                end else begin
                    n_idx   = r_idx + OCC_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_idx == r_pos) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                n_idx   = r_idx - OCC_W'(1);
                n_state = S_SHIFT_RD;
            end
            S_WRITE: begin
                n_occ   = r_occ + OCC_W'(1);
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_DQ_RD: begin
                n_state = S_DQ_OUT;
            end
            S_DQ_OUT: begin
                n_out_plate = PORT_W'(rd_plate);
                n_valid     = 1'b1;
                n_occ       = r_occ - OCC_W'(1);
                n_head      = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
            r_prio  <= tpq_pkg::PRIO_AGE_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_occ   <= n_occ;
            r_valid <= n_valid;
            if (i_cfg_valid) begin
                r_prio <= i_cfg_data;
            end
        end
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_plate     <= n_plate;
        r_age       <= n_age;
        r_out_plate <= n_out_plate;
        r_status    <= n_status;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_out_plate = r_out_plate;
    assign o_status    = r_status;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/tpq_ram.sv =====
// Generic single-port RAM with registered read.
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tpq_checker.sv =====
// Port-level assertions for the threshold priority queue, bound to the top level.
module tpq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               busy,
    input logic                               o_valid,
    input logic [tpq_pkg::PLATE_PORT_W-1:0]   o_out_plate,
    input logic [tpq_pkg::STATUS_W-1:0]       o_status
);

    // a result never shows while a long item is still in flight
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result beat while busy");

    // a multi-cycle item always ends with its result beat
    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("item finished without result beat");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == tpq_pkg::ST_DONE || o_status == tpq_pkg::ST_FULL
                     || o_status == tpq_pkg::ST_EMPTY))
        else $error("bad status code");

    a_err_plate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tpq_pkg::ST_DONE) |-> (o_out_plate == '0))
        else $error("nonzero plate on error beat");

endmodule

bind threshold_priority_queue_core tpq_checker u_tpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_out_plate (o_out_plate),
    .o_status    (o_status)
);
